// ===== hdl/mru_document_table_defines.svh =====
// assertion macros for the mru document table
// no dependencies; expects aclk and aresetn in the including module
`ifndef MRU_DOCUMENT_TABLE_DEFINES_SVH
`define MRU_DOCUMENT_TABLE_DEFINES_SVH

// condition must hold at every edge out of reset
`define MDT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// same-cycle implication
`define MDT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mdt_pkg.sv =====
// types and codes for the mru document table
// no dependencies
package mdt_pkg;

    // message kinds
    localparam logic [1:0] KIND_QUERY   = 2'd0;
    localparam logic [1:0] KIND_PUBLISH = 2'd1;

    // query modes; publish uses PUB_MODE_SKIP to mean ignore
    localparam logic [1:0] MODE_FORWARD    = 2'd0;
    localparam logic [1:0] MODE_ANSWER     = 2'd1;
    localparam logic [1:0] MODE_ANSWER_ALT = 2'd2;
    localparam logic [1:0] PUB_MODE_SKIP   = 2'd2;

    // result ports
    localparam logic [1:0] PORT_LINK     = 2'd0;
    localparam logic [1:0] PORT_HIT      = 2'd1;
    localparam logic [1:0] PORT_ANNOUNCE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] doc_id;
        logic [15:0] msg_id;
        logic [9:0]  peer_id;
        logic [1:0]  mode;
    } mdt_in_t;

    typedef struct packed {
        logic [1:0]  port;
        logic [15:0] doc_id_res;
        logic [15:0] msg_id_res;
        logic [9:0]  peer_id_res;
        logic [1:0]  fwd_mode;
    } mdt_out_t;

endpackage

// ===== hdl/mru_document_table.sv =====
// mru document table top level: recency-ordered id table in one memory
// depends on mdt_pkg and mru_document_table_defines.svh
// One item is taken at a time. A forwarded query (kind query, mode 0) or an
// ignored item goes straight to the finish state, and a forwarded query's
// result is loaded into the output register from there once it is free. A
// lookup or publish scans the table memory front to back, one entry per cycle
// through its single read port, while a publish shifts entries back by one on
// the same pass. A hit ends the scan early. A result waits in the output
// register while the next item is accepted. A new result stalls the block
// while the previous one is still waiting.
`include "mru_document_table_defines.svh"

module mru_document_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mdt_pkg::mdt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mdt_pkg::mdt_out_t m_data
);
    import mdt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_FIN
    } state_t;

    state_t          state_reg, state_next;
    mdt_in_t         item_reg, item_next;
    logic            is_pub_reg, is_pub_next;
    logic            has_res_reg, has_res_next;
    logic [1:0]      res_port_reg, res_port_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic            cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [15:0]     carry_reg, carry_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            m_valid_reg, m_valid_next;
    mdt_out_t        m_data_reg, m_data_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [15:0]     rd_data_reg;
    logic            hit;

    logic [15:0]     doc_entries [TABLE_DEPTH];

    // table memory, one write and one read port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            doc_entries[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= doc_entries[mem_raddr];
        end
    end

    assign hit = cmp_valid_reg && (rd_data_reg == item_reg.doc_id);

    // sequencer: scan, with move-to-front for a publish on the same pass
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        is_pub_next    = is_pub_reg;
        has_res_next   = has_res_reg;
        res_port_next  = res_port_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        carry_next     = carry_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = cmp_idx_reg;
        mem_wdata      = carry_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_idx_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next     = s_data;
                    carry_next    = s_data.doc_id;
                    rd_idx_next   = '0;
                    is_pub_next   = 1'b0;
                    has_res_next  = 1'b0;
                    res_port_next = PORT_LINK;
                    if (s_data.kind == KIND_QUERY && s_data.mode == MODE_FORWARD) begin
                        has_res_next = 1'b1;
                        state_next   = ST_FIN;
                    end else if (s_data.kind == KIND_QUERY &&
                                 (s_data.mode == MODE_ANSWER ||
                                  s_data.mode == MODE_ANSWER_ALT)) begin
                        res_port_next = PORT_HIT;
                        state_next    = ST_SCAN;
                    end else if (s_data.kind == KIND_PUBLISH &&
                                 s_data.mode != PUB_MODE_SKIP) begin
                        is_pub_next   = 1'b1;
                        res_port_next = PORT_ANNOUNCE;
                        state_next    = ST_SCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                // publish: each compared slot takes the previous entry
                if (cmp_valid_reg && is_pub_reg) begin
                    mem_we     = 1'b1;
                    mem_waddr  = cmp_idx_reg;
                    mem_wdata  = carry_reg;
                    carry_next = rd_data_reg;
                end
                if (hit) begin
                    has_res_next = !is_pub_reg;
                    state_next   = ST_FIN;
                end else if (rd_idx_reg == count_reg) begin
                    if (is_pub_reg) begin
                        state_next = ST_APPEND;
                    end else begin
                        has_res_next = 1'b0;
                        state_next   = ST_FIN;
                    end
                end else begin
                    mem_re         = 1'b1;
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[AW-1:0];
                end
            end
            ST_APPEND: begin
                // new id: the displaced last entry grows the table or is dropped
                if (count_reg < DEPTH_C) begin
                    mem_we     = 1'b1;
                    mem_waddr  = count_reg[AW-1:0];
                    mem_wdata  = carry_reg;
                    count_next = count_reg + 1'b1;
                end
                has_res_next = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                if (!has_res_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.port        = res_port_reg;
                    m_data_next.doc_id_res  = item_reg.doc_id;
                    m_data_next.msg_id_res  = item_reg.msg_id;
                    m_data_next.peer_id_res = item_reg.peer_id;
                    m_data_next.fwd_mode    = (res_port_reg == PORT_LINK) ? item_reg.mode : 2'd0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
        item_reg     <= item_next;
        is_pub_reg   <= is_pub_next;
        has_res_reg  <= has_res_next;
        res_port_reg <= res_port_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        carry_reg    <= carry_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `MDT_ASSERT_ALWAYS(a_count_bound, count_reg <= DEPTH_C, "entry count above table depth")
    `MDT_ASSERT_NEXT(a_count_only_append, state_reg != ST_APPEND, $stable(count_reg), "count changed outside append")
    `MDT_ASSERT_IMP(a_write_state, mem_we, (state_reg == ST_SCAN) || (state_reg == ST_APPEND), "table write outside scan or append")
    `MDT_ASSERT_IMP(a_cmp_in_scan, cmp_valid_reg, state_reg == ST_SCAN, "compare pending outside scan")
    `MDT_ASSERT_IMP(a_scan_range, state_reg == ST_SCAN, rd_idx_reg <= count_reg, "scan index past entry count")

endmodule
